[hdl/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, item codes and command constants for the two-wire
// seven-segment display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Number of digit entries held in the digit store
  localparam int unsigned NUM_STORE = 6;

  // Item kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_DIGITS  = 2'd1;
  localparam logic [1:0] KIND_CONTROL = 2'd2;

  // Bus command bytes
  localparam logic [7:0] CMD_DATA = 8'h40;
  localparam logic [7:0] CMD_ADDR = 8'hC0;
  localparam logic [7:0] CMD_CTRL = 8'h80;
  localparam logic [7:0] CTRL_ON  = 8'h08;

  // Input item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] digit0;
    logic [7:0] digit1;
    logic [7:0] digit2;
    logic [7:0] digit3;
    logic [7:0] digit4;
    logic [7:0] digit5;
    logic [2:0] level;
    logic       lit;
    logic       dio_in;
  } item_t;

  // Result item
  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic dio_drive;
    logic busy_res;
    logic ack_valid;
    logic ack_ok;
    logic rejected;
    logic done_res;
  } res_t;

  // Physical byte position to logical digit entry
  function automatic logic [2:0] phys_digit(input logic [2:0] pos);
    logic [2:0] idx;
    case (pos)
      3'd0:    idx = 3'd2;
      3'd1:    idx = 3'd1;
      3'd2:    idx = 3'd0;
      3'd3:    idx = 3'd5;
      3'd4:    idx = 3'd4;
      3'd5:    idx = 3'd3;
      default: idx = 3'd0;
    endcase
    return idx;
  endfunction

endpackage

[hdl/ssd_digits.sv]
// ----------------------------------------------------------------------------
// ssd_digits
// Six-entry digit store, loaded at once by a digit update, read at one
// physical byte position through a registered read port.
// ----------------------------------------------------------------------------
module ssd_digits (
  input  logic          clk,
  input  logic          load,
  input  ssd_pkg::item_t item,
  input  logic [2:0]    pos,
  output logic [7:0]    digit
);

  logic [7:0] store [ssd_pkg::NUM_STORE];

  // Load all entries from one digit update item
  always_ff @(posedge clk) begin
    if (load) begin
      store[0] <= item.digit0;
      store[1] <= item.digit1;
      store[2] <= item.digit2;
      store[3] <= item.digit3;
      store[4] <= item.digit4;
      store[5] <= item.digit5;
    end
  end

  // Read the logical entry for the physical position; the position holds for a
  // whole byte of bus phases, so the registered value is current when used
  always_ff @(posedge clk) begin
    digit <= store[ssd_pkg::phys_digit(pos)];
  end

endmodule

[hdl/ssd_seq.sv]
// ----------------------------------------------------------------------------
// ssd_seq
// Bus phase sequencer: start, bits, acknowledge and stop parts, frame and
// byte counters, pin levels and the result item for each processed item.
// ----------------------------------------------------------------------------
module ssd_seq #(
  parameter int unsigned DIGITS = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  ssd_pkg::item_t item,
  input  logic [7:0]     digit,
  output logic [2:0]     pos,
  output logic           load,
  output ssd_pkg::res_t  res
);

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_DIGITS  = 2'd1;
  localparam logic [1:0] MODE_CONTROL = 2'd2;

  localparam logic [1:0] PART_START = 2'd0;
  localparam logic [1:0] PART_BITS  = 2'd1;
  localparam logic [1:0] PART_ACK   = 2'd2;
  localparam logic [1:0] PART_STOP  = 2'd3;

  localparam logic [2:0] LAST_BYTE = 3'(DIGITS);

  logic [1:0] mode, mode_next;
  logic [1:0] part, part_next;
  logic [2:0] phase, phase_next;
  logic [1:0] frame, frame_next;
  logic [2:0] byte_idx, byte_idx_next;
  logic [2:0] bit_idx, bit_idx_next;
  logic [7:0] shift, shift_next;
  logic [2:0] bright, bright_next;
  logic       ctl_on, ctl_on_next;
  logic       pin_clk, pin_clk_next;
  logic       pin_dio, pin_dio_next;
  logic       dio_drv, dio_drv_next;
  logic       busy;
  logic       ack_valid, rejected, done;
  logic [7:0] first_byte;

  assign busy = (mode != MODE_IDLE);
  assign pos  = byte_idx;
  assign load = go && (item.kind == ssd_pkg::KIND_DIGITS) && !busy;

  // Pick the first byte of the current frame
  always_comb begin
    case (frame)
      2'd0:    first_byte = ssd_pkg::CMD_DATA;
      2'd1:    first_byte = ssd_pkg::CMD_ADDR;
      default: begin
        if (mode == MODE_CONTROL) begin
          first_byte = ssd_pkg::CMD_CTRL | (ctl_on ? ssd_pkg::CTRL_ON : 8'h00) |
                       {5'd0, bright};
        end else begin
          first_byte = ssd_pkg::CMD_CTRL | ssd_pkg::CTRL_ON | {5'd0, bright};
        end
      end
    endcase
  end

  // Advance the sequencer by one item
  always_comb begin
    mode_next     = mode;
    part_next     = part;
    phase_next    = phase;
    frame_next    = frame;
    byte_idx_next = byte_idx;
    bit_idx_next  = bit_idx;
    shift_next    = shift;
    bright_next   = bright;
    ctl_on_next   = ctl_on;
    pin_clk_next  = pin_clk;
    pin_dio_next  = pin_dio;
    dio_drv_next  = dio_drv;
    ack_valid     = 1'b0;
    rejected      = 1'b0;
    done          = 1'b0;
    case (item.kind)
      ssd_pkg::KIND_TICK: begin
        if (busy) begin
          case (part)
            PART_START: begin
              if (phase == 3'd0) begin
                pin_clk_next = 1'b1;
                pin_dio_next = 1'b1;
                dio_drv_next = 1'b1;
                phase_next   = 3'd1;
              end else if (phase == 3'd1) begin
                pin_dio_next = 1'b0;
                dio_drv_next = 1'b1;
                phase_next   = 3'd2;
              end else begin
                pin_clk_next  = 1'b0;
                part_next     = PART_BITS;
                phase_next    = 3'd0;
                bit_idx_next  = 3'd0;
                byte_idx_next = 3'd0;
                shift_next    = first_byte;
              end
            end
            PART_BITS: begin
              if (phase == 3'd0) begin
                pin_clk_next = 1'b0;
                phase_next   = 3'd1;
              end else if (phase == 3'd1) begin
                pin_dio_next = shift[0];
                dio_drv_next = 1'b1;
                phase_next   = 3'd2;
              end else begin
                pin_clk_next = 1'b1;
                shift_next   = {1'b0, shift[7:1]};
                bit_idx_next = bit_idx + 3'd1;
                phase_next   = 3'd0;
                if (bit_idx == 3'd7) begin
                  part_next = PART_ACK;
                end
              end
            end
            PART_ACK: begin
              if (phase == 3'd0) begin
                pin_clk_next = 1'b0;
                phase_next   = 3'd1;
              end else if (phase == 3'd1) begin
                pin_dio_next = 1'b1;
                dio_drv_next = 1'b0;
                phase_next   = 3'd2;
              end else if (phase == 3'd2) begin
                pin_clk_next = 1'b1;
                ack_valid    = 1'b1;
                phase_next   = 3'd3;
              end else if (phase == 3'd3) begin
                pin_clk_next = 1'b0;
                phase_next   = 3'd4;
              end else begin
                pin_dio_next  = 1'b1;
                dio_drv_next  = 1'b1;
                phase_next    = 3'd0;
                byte_idx_next = byte_idx + 3'd1;
                // Only the address frame carries digit bytes after its first
                if ((frame == 2'd1) && (byte_idx < LAST_BYTE)) begin
                  part_next    = PART_BITS;
                  bit_idx_next = 3'd0;
                  shift_next   = digit;
                end else begin
                  part_next = PART_STOP;
                end
              end
            end
            default: begin
              if (phase == 3'd0) begin
                pin_clk_next = 1'b0;
                phase_next   = 3'd1;
              end else if (phase == 3'd1) begin
                pin_dio_next = 1'b0;
                dio_drv_next = 1'b1;
                phase_next   = 3'd2;
              end else if (phase == 3'd2) begin
                pin_clk_next = 1'b1;
                phase_next   = 3'd3;
              end else begin
                pin_dio_next  = 1'b1;
                dio_drv_next  = 1'b1;
                phase_next    = 3'd0;
                byte_idx_next = 3'd0;
                part_next     = PART_START;
                if (frame < 2'd2) begin
                  frame_next = frame + 2'd1;
                end else begin
                  frame_next = 2'd0;
                  mode_next  = MODE_IDLE;
                  done       = 1'b1;
                end
              end
            end
          endcase
        end
      end
      ssd_pkg::KIND_DIGITS, ssd_pkg::KIND_CONTROL: begin
        if (busy) begin
          rejected = 1'b1;
        end else begin
          mode_next     = (item.kind == ssd_pkg::KIND_DIGITS) ? MODE_DIGITS : MODE_CONTROL;
          frame_next    = (item.kind == ssd_pkg::KIND_DIGITS) ? 2'd0 : 2'd2;
          byte_idx_next = 3'd0;
          bit_idx_next  = 3'd0;
          phase_next    = 3'd0;
          part_next     = PART_START;
          if (item.kind == ssd_pkg::KIND_CONTROL) begin
            bright_next = item.level;
            ctl_on_next = item.lit;
          end
        end
      end
      default: begin
        // Unused kind: no effect
      end
    endcase
  end

  // Build the result item from the updated state
  always_comb begin
    res.clk_level = pin_clk_next;
    res.dio_level = pin_dio_next;
    res.dio_drive = dio_drv_next;
    res.busy_res  = (mode_next != MODE_IDLE);
    res.ack_valid = ack_valid;
    res.ack_ok    = ack_valid && !item.dio_in;
    res.rejected  = rejected;
    res.done_res  = done;
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      part     <= PART_START;
      phase    <= 3'd0;
      frame    <= 2'd0;
      byte_idx <= 3'd0;
      bit_idx  <= 3'd0;
      shift    <= 8'd0;
      bright   <= 3'd7;
      ctl_on   <= 1'b1;
      pin_clk  <= 1'b1;
      pin_dio  <= 1'b1;
      dio_drv  <= 1'b1;
    end else if (go) begin
      mode     <= mode_next;
      part     <= part_next;
      phase    <= phase_next;
      frame    <= frame_next;
      byte_idx <= byte_idx_next;
      bit_idx  <= bit_idx_next;
      shift    <= shift_next;
      bright   <= bright_next;
      ctl_on   <= ctl_on_next;
      pin_clk  <= pin_clk_next;
      pin_dio  <= pin_dio_next;
      dio_drv  <= dio_drv_next;
    end
  end

  // An idle sequencer always waits at the first start phase
  a_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_IDLE) |-> ((part == PART_START) && (phase == 3'd0)))
    else $error("idle sequencer not parked at start");

  // A released data line reads as pulled high
  a_release_high: assert property (@(posedge clk) disable iff (rst)
    !dio_drv |-> pin_dio)
    else $error("released data line not high");

  // Phase counter stays inside the length of its part
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    ((part == PART_START) && (phase <= 3'd2)) || ((part == PART_BITS) && (phase <= 3'd2)) ||
    ((part == PART_ACK) && (phase <= 3'd4)) || ((part == PART_STOP) && (phase <= 3'd3)))
    else $error("phase out of range for bus part");

  // Byte counter passes the last digit byte only on the way into the stop part
  a_byte_range: assert property (@(posedge clk) disable iff (rst)
    (byte_idx > LAST_BYTE) |-> (part == PART_STOP))
    else $error("byte index beyond frame");

endmodule

[hdl/seven_segment_twowire_driver.sv]
// ----------------------------------------------------------------------------
// seven_segment_twowire_driver
// Two-wire bus master for a seven-segment display: one bus phase per tick
// item, digit updates and control requests start frame sequences.
// ----------------------------------------------------------------------------
// Path: the input register holds an accepted item, then the sequencer step
//   writes its result into the result register.
// Throughput: 1 item per cycle without res_stall; one phase per busy tick.
// Reset: clears both handshake stages and parks the sequencer idle with
//   clock and data lines high, brightness 7, display on.
// ----------------------------------------------------------------------------
module seven_segment_twowire_driver #(
  parameter int unsigned DIGITS = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  ssd_pkg::item_t item,
  output logic           res_valid,
  input  logic           res_stall,
  output ssd_pkg::res_t  res
);

  logic           in_full;
  ssd_pkg::item_t in_item;
  logic           out_full;
  ssd_pkg::res_t  out_res;
  ssd_pkg::res_t  step_res;
  logic           go;
  logic           load;
  logic [2:0]     pos;
  logic [7:0]     digit;

  // Process the held item when the result register can take it
  assign go         = in_full && (!out_full || !res_stall);
  assign item_stall = in_full && !go;
  assign res_valid  = out_full;
  assign res        = out_res;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_full <= 1'b1;
    end else if (go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_item <= item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (go) begin
      out_full <= 1'b1;
    end else if (!res_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_res <= step_res;
    end
  end

  ssd_digits u_digits (
    .clk   (clk),
    .load  (load),
    .item  (in_item),
    .pos   (pos),
    .digit (digit)
  );

  ssd_seq #(
    .DIGITS (DIGITS)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .item  (in_item),
    .digit (digit),
    .pos   (pos),
    .load  (load),
    .res   (step_res)
  );

endmodule

[bench/ssd_bench_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssd_bench_pkg
// Pin-level scoreboard for the two-wire display driver: a cycle-free model of
// the frame sequencer predicts the bus pins and status flags for each item.
// ----------------------------------------------------------------------------
package ssd_bench_pkg;

  // Kind code the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Bytes in the address frame after the address command
  localparam int unsigned DIGIT_BYTES = 6;

  // Physical byte position to logical digit, three bits per position
  localparam logic [17:0] PHYS_ORDER = {3'd3, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2};

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_DIGITS, SEQ_CONTROL} seq_mode_e;
  typedef enum logic [1:0] {BUS_START, BUS_BITS, BUS_ACK, BUS_STOP} bus_sec_e;

  class bus_phase_scoreboard;

    ssd_pkg::res_t expected_pins[$];
    int        mismatches;

    logic [7:0] digit_mem [ssd_pkg::NUM_STORE];
    logic [2:0] bright;
    logic       disp_on;
    logic [1:0] frame_cnt;
    logic [2:0] byte_cnt;
    logic [3:0] bit_cnt;
    logic [2:0] phase_cnt;
    logic [7:0] shreg;
    seq_mode_e  mode;
    bus_sec_e   bus_sec;
    logic       pin_clk;
    logic       pin_dio;
    logic       dio_drv;

    function new();
      foreach (digit_mem[i]) digit_mem[i] = 8'h00;
      bright    = 3'd7;
      disp_on   = 1'b1;
      frame_cnt = 2'd0;
      byte_cnt  = 3'd0;
      bit_cnt   = 4'd0;
      phase_cnt = 3'd0;
      shreg     = 8'h00;
      mode      = SEQ_IDLE;
      bus_sec   = BUS_START;
      pin_clk   = 1'b1;
      pin_dio   = 1'b1;
      dio_drv   = 1'b1;
      mismatches = 0;
    endfunction

    function bit busy();
      return mode != SEQ_IDLE;
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction

    // Pick the byte for the current frame and byte position
    function logic [7:0] next_byte();
      logic [2:0] pos;
      if (frame_cnt == 2'd0) return ssd_pkg::CMD_DATA;
      if (frame_cnt == 2'd1) begin
        if (byte_cnt == 3'd0) return ssd_pkg::CMD_ADDR;
        pos = byte_cnt - 3'd1;
        return digit_mem[PHYS_ORDER[3*pos +: 3]];
      end
      if (mode == SEQ_CONTROL)
        return ssd_pkg::CMD_CTRL | (disp_on ? ssd_pkg::CTRL_ON : 8'h00) | {5'b0, bright};
      // digit updates always switch the display on
      return ssd_pkg::CMD_CTRL | ssd_pkg::CTRL_ON | {5'b0, bright};
    endfunction

    function void open_sequence(seq_mode_e m, logic [1:0] first);
      mode      = m;
      frame_cnt = first;
      byte_cnt  = 3'd0;
      bit_cnt   = 4'd0;
      phase_cnt = 3'd0;
      bus_sec   = BUS_START;
    endfunction

    // Advance the bus by one phase
    function void run_phase(output logic ack_v, output logic fin);
      ack_v = 1'b0;
      fin   = 1'b0;
      case (bus_sec)
        BUS_START: begin
          if (phase_cnt == 3'd0) begin
            pin_clk = 1'b1; pin_dio = 1'b1; dio_drv = 1'b1; phase_cnt = 3'd1;
          end else if (phase_cnt == 3'd1) begin
            pin_dio = 1'b0; dio_drv = 1'b1; phase_cnt = 3'd2;
          end else begin
            pin_clk = 1'b0;
            bus_sec = BUS_BITS; phase_cnt = 3'd0; bit_cnt = 4'd0; byte_cnt = 3'd0;
            shreg = next_byte();
          end
        end
        BUS_BITS: begin
          if (phase_cnt == 3'd0) begin
            pin_clk = 1'b0; phase_cnt = 3'd1;
          end else if (phase_cnt == 3'd1) begin
            pin_dio = shreg[0]; dio_drv = 1'b1; phase_cnt = 3'd2;
          end else begin
            pin_clk = 1'b1;
            shreg = shreg >> 1;
            bit_cnt = bit_cnt + 4'd1;
            phase_cnt = 3'd0;
            if (bit_cnt >= 4'd8) begin
              bus_sec = BUS_ACK; bit_cnt = 4'd0;
            end
          end
        end
        BUS_ACK: begin
          if (phase_cnt == 3'd0) begin
            pin_clk = 1'b0; phase_cnt = 3'd1;
          end else if (phase_cnt == 3'd1) begin
            // release data, pull-up reads high
            pin_dio = 1'b1; dio_drv = 1'b0; phase_cnt = 3'd2;
          end else if (phase_cnt == 3'd2) begin
            pin_clk = 1'b1; ack_v = 1'b1; phase_cnt = 3'd3;
          end else if (phase_cnt == 3'd3) begin
            pin_clk = 1'b0; phase_cnt = 3'd4;
          end else begin
            pin_dio = 1'b1; dio_drv = 1'b1; phase_cnt = 3'd0;
            byte_cnt = byte_cnt + 3'd1;
            if (byte_cnt < ((frame_cnt == 2'd1) ? 3'(DIGIT_BYTES + 1) : 3'd1)) begin
              bus_sec = BUS_BITS; bit_cnt = 4'd0;
              shreg = next_byte();
            end else begin
              bus_sec = BUS_STOP;
            end
          end
        end
        default: begin
          if (phase_cnt == 3'd0) begin
            pin_clk = 1'b0; phase_cnt = 3'd1;
          end else if (phase_cnt == 3'd1) begin
            pin_dio = 1'b0; dio_drv = 1'b1; phase_cnt = 3'd2;
          end else if (phase_cnt == 3'd2) begin
            pin_clk = 1'b1; phase_cnt = 3'd3;
          end else begin
            pin_dio = 1'b1; dio_drv = 1'b1; phase_cnt = 3'd0;
            byte_cnt = 3'd0;
            bus_sec = BUS_START;
            if (frame_cnt < 2'd2) begin
              frame_cnt = frame_cnt + 2'd1;
            end else begin
              frame_cnt = 2'd0;
              mode = SEQ_IDLE;
              fin = 1'b1;
            end
          end
        end
      endcase
    endfunction

    // Predict the result of one accepted item and queue it
    function void note_item(ssd_pkg::item_t it);
      ssd_pkg::res_t exp;
      logic ack_v;
      logic fin;
      exp = '0;
      if (it.kind == ssd_pkg::KIND_TICK) begin
        if (mode != SEQ_IDLE) begin
          run_phase(ack_v, fin);
          exp.ack_valid = ack_v;
          exp.ack_ok    = ack_v && !it.dio_in;
          exp.done_res  = fin;
        end
      end else if (it.kind == ssd_pkg::KIND_DIGITS || it.kind == ssd_pkg::KIND_CONTROL) begin
        if (mode != SEQ_IDLE) begin
          exp.rejected = 1'b1;
        end else if (it.kind == ssd_pkg::KIND_DIGITS) begin
          digit_mem[0] = it.digit0;
          digit_mem[1] = it.digit1;
          digit_mem[2] = it.digit2;
          digit_mem[3] = it.digit3;
          digit_mem[4] = it.digit4;
          digit_mem[5] = it.digit5;
          open_sequence(SEQ_DIGITS, 2'd0);
        end else begin
          bright  = it.level;
          disp_on = it.lit;
          open_sequence(SEQ_CONTROL, 2'd2);
        end
      end
      exp.clk_level = pin_clk;
      exp.dio_level = pin_dio;
      exp.dio_drive = dio_drv;
      exp.busy_res  = (mode != SEQ_IDLE);
      expected_pins.push_back(exp);
    endfunction

    function void compare_field(string fname, logic e, logic g);
      if (e !== g) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0b, got %0b", $time, fname, e, g);
      end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(ssd_pkg::res_t got);
      ssd_pkg::res_t exp;
      if (expected_pins.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %b", $time, got);
        return;
      end
      exp = expected_pins.pop_front();
      compare_field("clk_level", exp.clk_level, got.clk_level);
      compare_field("dio_level", exp.dio_level, got.dio_level);
      compare_field("dio_drive", exp.dio_drive, got.dio_drive);
      compare_field("busy_res",  exp.busy_res,  got.busy_res);
      compare_field("ack_valid", exp.ack_valid, got.ack_valid);
      compare_field("ack_ok",    exp.ack_ok,    got.ack_ok);
      compare_field("rejected",  exp.rejected,  got.rejected);
      compare_field("done_res",  exp.done_res,  got.done_res);
    endfunction

  endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the display driver with requests and bus ticks under random idle
// and back-pressure, and checks every result against the pin scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ITEM_TARGET = 1050;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_LEN    = 120;
  localparam int CALM_AT     = 900;
  localparam int CALM_LEN    = 250;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           item_valid = 1'b0;
  logic           item_stall;
  ssd_pkg::item_t item = '0;
  logic           res_valid;
  logic           res_stall = 1'b0;
  ssd_pkg::res_t  res;

  ssd_bench_pkg::bus_phase_scoreboard sb;
  int    all_sent = 0;
  int    rx_cycle = 0;

  seven_segment_twowire_driver dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

  always #5 clk = ~clk;

  // Favor the all-zero and all-one segment patterns
  function automatic logic [7:0] rand_digit();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic ssd_pkg::item_t make_item(input logic [1:0] k);
    ssd_pkg::item_t it;
    it.kind   = k;
    it.digit0 = rand_digit();
    it.digit1 = rand_digit();
    it.digit2 = rand_digit();
    it.digit3 = rand_digit();
    it.digit4 = rand_digit();
    it.digit5 = rand_digit();
    it.level  = 3'($urandom_range(7));
    it.lit    = 1'($urandom_range(1));
    it.dio_in = 1'($urandom_range(1));
    return it;
  endfunction

  // Offer one item, idling at random first except while items 500 to 699 go out, and hold it until taken
  task automatic send_item(input ssd_pkg::item_t it);
    while (!(all_sent >= 500 && all_sent < 700) && $urandom_range(99) < 19) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
    all_sent++;
  endtask

  // Result side: random stalls, one long hold-off, one calm stretch
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      rx_cycle  <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_LEN)
        res_stall <= 1'b1;
      else if (rx_cycle >= CALM_AT && rx_cycle < CALM_AT + CALM_LEN)
        res_stall <= 1'b0;
      else
        res_stall <= ($urandom_range(99) < 19);
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(res);
  end

  initial begin
    ssd_pkg::item_t it;
    int unsigned    r;
    logic [1:0]     k;
    bit             was_busy;

    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle ticks, ignored kind, control with lowest level and off,
    // requests while busy, then ticks into the control frame
    it = make_item(ssd_pkg::KIND_TICK);    it.dio_in = 1'b0; send_item(it);
    it = make_item(ssd_pkg::KIND_TICK);    it.dio_in = 1'b1; send_item(it);
    it = make_item(ssd_bench_pkg::KIND_UNUSED); send_item(it);
    it = make_item(ssd_pkg::KIND_CONTROL);
    it.level = 3'd0; it.lit = 1'b0; send_item(it);
    it = make_item(ssd_pkg::KIND_CONTROL);
    it.level = 3'd7; it.lit = 1'b1; send_item(it);
    it = make_item(ssd_pkg::KIND_DIGITS);  send_item(it);
    it = make_item(ssd_bench_pkg::KIND_UNUSED); send_item(it);
    repeat (18) send_item(make_item(ssd_pkg::KIND_TICK));

    // Random: mostly complete sequences, some requests and noise while busy
    while (all_sent < ITEM_TARGET) begin
      was_busy = sb.busy();
      r = $urandom_range(99);
      if (was_busy) begin
        if (r < 90)      k = ssd_pkg::KIND_TICK;
        else if (r < 94) k = ssd_pkg::KIND_DIGITS;
        else if (r < 97) k = ssd_pkg::KIND_CONTROL;
        else             k = ssd_bench_pkg::KIND_UNUSED;
      end else begin
        if (r < 35)      k = ssd_pkg::KIND_DIGITS;
        else if (r < 85) k = ssd_pkg::KIND_CONTROL;
        else if (r < 93) k = ssd_pkg::KIND_TICK;
        else             k = ssd_bench_pkg::KIND_UNUSED;
      end
      send_item(make_item(k));
    end
    item_valid <= 1'b0;

    // Drain, then allow for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("seven_segment_twowire_driver verification clean");
    else
      $display("seven_segment_twowire_driver verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("seven_segment_twowire_driver verification failed");
    $finish;
  end

endmodule

[seven_segment_twowire_driver.f]
hdl/ssd_pkg.sv
hdl/ssd_digits.sv
hdl/ssd_seq.sv
hdl/seven_segment_twowire_driver.sv
bench/ssd_bench_pkg.sv
bench/tb_top.sv
